>>> rtl/assert_macros.svh
// assertion macros used by the table datapath
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge outside reset
`define ASSERT_HOLDS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// implication checked in the same cycle outside reset
`define ASSERT_IMPLIES(lbl, cond, expr, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |-> (expr)) \
        else $error(msg);

`endif

>>> rtl/fckvt_pkg.sv
// types, codes and constants of the key/value table
package fckvt_pkg;

    localparam int CAPACITY_DEF   = 16;
    localparam int KEY_BITS_DEF   = 32;
    localparam int VALUE_BITS_DEF = 32;

    localparam int ACTION_W    = 3;
    localparam int INDEX_W     = 8;
    localparam int FOUND_W     = 32;
    localparam int COUNT_OUT_W = 5;

    typedef enum logic [ACTION_W-1:0] {
        ACT_INSERT = 3'd0,
        ACT_UPDATE = 3'd1,
        ACT_UPSERT = 3'd2,
        ACT_ERASE  = 3'd3,
        ACT_LOOKUP = 3'd4,
        ACT_READ   = 3'd5
    } t_action;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_MOVE,
        ST_RESULT
    } t_state;

    typedef enum logic [1:0] {
        RD_SCAN,
        RD_INDEX,
        RD_LAST
    } t_rd_sel;

    typedef enum logic [1:0] {
        WR_APPEND,
        WR_MATCH,
        WR_MOVE
    } t_wr_sel;

    typedef enum logic [1:0] {
        RES_NONE,
        RES_VALUE,
        RES_PAIR
    } t_res_kind;

    typedef struct packed {
        logic      load;
        logic      scan;
        logic      rd_en;
        t_rd_sel   rd_sel;
        logic      wr_en;
        t_wr_sel   wr_sel;
        logic      cnt_inc;
        logic      cnt_dec;
        logic      res_set;
        logic      res_ok;
        t_res_kind res_kind;
        logic      out_load;
    } t_cmd;

    typedef struct packed {
        t_action act;
        logic    match;
        logic    miss;
        logic    scan_more;
        logic    full;
        logic    hit_is_last;
        logic    idx_ok;
        logic    out_free;
    } t_sts;

endpackage

>>> rtl/fckvt_ctrl.sv
// controller state machine: sequences search, write-back and result transfer
module fckvt_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  fckvt_pkg::t_sts i_sts,
    output fckvt_pkg::t_cmd o_cmd,
    output logic            o_stall
);
    import fckvt_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_stall = (r_state != ST_IDLE);
        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_SCAN;
                end
            end
            ST_SCAN: begin
                case (i_sts.act)
                    ACT_READ: begin
                        o_cmd.res_set = 1'b1;
                        if (i_sts.idx_ok) begin
                            o_cmd.rd_en    = 1'b1;
                            o_cmd.rd_sel   = RD_INDEX;
                            o_cmd.res_ok   = 1'b1;
                            o_cmd.res_kind = RES_PAIR;
                        end
                        n_state = ST_RESULT;
                    end
                    ACT_INSERT, ACT_UPDATE, ACT_UPSERT, ACT_ERASE, ACT_LOOKUP: begin
                        if (i_sts.match) begin
                            o_cmd.res_set = 1'b1;
                            n_state       = ST_RESULT;
                            if (i_sts.act == ACT_UPDATE || i_sts.act == ACT_UPSERT) begin
                                o_cmd.wr_en  = 1'b1;
                                o_cmd.wr_sel = WR_MATCH;
                                o_cmd.res_ok = 1'b1;
                            end else if (i_sts.act == ACT_LOOKUP) begin
                                o_cmd.res_ok   = 1'b1;
                                o_cmd.res_kind = RES_VALUE;
                            end else if (i_sts.act == ACT_ERASE) begin
                                o_cmd.res_ok = 1'b1;
                                if (i_sts.hit_is_last) begin
                                    o_cmd.cnt_dec = 1'b1;
                                end else begin
                                    // fetch the last pair to fill the hole
                                    o_cmd.res_set = 1'b0;
                                    o_cmd.rd_en   = 1'b1;
                                    o_cmd.rd_sel  = RD_LAST;
                                    n_state       = ST_MOVE;
                                end
                            end
                        end else if (i_sts.miss) begin
                            o_cmd.res_set = 1'b1;
                            n_state       = ST_RESULT;
                            if ((i_sts.act == ACT_INSERT || i_sts.act == ACT_UPSERT)
                                && !i_sts.full) begin
                                o_cmd.wr_en   = 1'b1;
                                o_cmd.wr_sel  = WR_APPEND;
                                o_cmd.cnt_inc = 1'b1;
                                o_cmd.res_ok  = 1'b1;
                            end
                        end else if (i_sts.scan_more) begin
                            o_cmd.scan   = 1'b1;
                            o_cmd.rd_en  = 1'b1;
                            o_cmd.rd_sel = RD_SCAN;
                        end
                    end
                    default: begin
                        o_cmd.res_set = 1'b1;
                        n_state       = ST_RESULT;
                    end
                endcase
            end
            ST_MOVE: begin
                o_cmd.wr_en   = 1'b1;
                o_cmd.wr_sel  = WR_MOVE;
                o_cmd.cnt_dec = 1'b1;
                o_cmd.res_set = 1'b1;
                o_cmd.res_ok  = 1'b1;
                n_state       = ST_RESULT;
            end
            ST_RESULT: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

>>> rtl/fckvt_dpath.sv
// datapath: slot memory, request and count registers, key compare, result register
module fckvt_dpath #(
    parameter int CAPACITY   = fckvt_pkg::CAPACITY_DEF,
    parameter int KEY_BITS   = fckvt_pkg::KEY_BITS_DEF,
    parameter int VALUE_BITS = fckvt_pkg::VALUE_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  fckvt_pkg::t_cmd                     i_cmd,
    output fckvt_pkg::t_sts                     o_sts,
    input  logic [fckvt_pkg::ACTION_W-1:0]      i_action,
    input  logic [KEY_BITS-1:0]                 i_req_key,
    input  logic [VALUE_BITS-1:0]               i_req_value,
    input  logic [fckvt_pkg::INDEX_W-1:0]       i_slot_index,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic                                o_ok,
    output logic [fckvt_pkg::FOUND_W-1:0]       o_found_key,
    output logic [fckvt_pkg::FOUND_W-1:0]       o_found_value,
    output logic [fckvt_pkg::COUNT_OUT_W-1:0]   o_entry_count
);
    import fckvt_pkg::*;

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int DW = KEY_BITS + VALUE_BITS;
    localparam int XW = CW + INDEX_W;

    logic [DW-1:0] mem [CAPACITY];

    t_action               r_act;
    logic [KEY_BITS-1:0]   r_key;
    logic [VALUE_BITS-1:0] r_val;
    logic [INDEX_W-1:0]    r_idx;
    logic [CW-1:0]         r_count;
    logic [CW-1:0]         r_scan;
    logic                  r_pv;
    logic [AW-1:0]         r_pidx;
    logic [DW-1:0]         r_rd_data;
    logic                  r_res_ok;
    t_res_kind             r_res_kind;
    logic                  r_out_valid;
    logic                  r_ok;
    logic [FOUND_W-1:0]    r_fkey;
    logic [FOUND_W-1:0]    r_fval;
    logic [COUNT_OUT_W-1:0] r_ecount;

    logic [AW-1:0]         last_slot;
    logic [AW-1:0]         rd_addr;
    logic [AW-1:0]         wr_addr;
    logic [DW-1:0]         wr_data;
    logic [KEY_BITS-1:0]   rd_key;
    logic [VALUE_BITS-1:0] rd_val;

    assign last_slot = AW'(r_count - CW'(1));
    assign rd_key    = r_rd_data[DW-1:VALUE_BITS];
    assign rd_val    = r_rd_data[VALUE_BITS-1:0];

    always_comb begin
        case (i_cmd.rd_sel)
            RD_SCAN:  rd_addr = AW'(r_scan);
            RD_INDEX: rd_addr = AW'(r_idx);
            RD_LAST:  rd_addr = last_slot;
            default:  rd_addr = AW'(r_scan);
        endcase
    end

    always_comb begin
        case (i_cmd.wr_sel)
            WR_APPEND: begin
                wr_addr = AW'(r_count);
                wr_data = {r_key, r_val};
            end
            WR_MATCH: begin
                wr_addr = r_pidx;
                wr_data = {r_key, r_val};
            end
            WR_MOVE: begin
                wr_addr = r_pidx;
                wr_data = r_rd_data;
            end
            default: begin
                wr_addr = r_pidx;
                wr_data = {r_key, r_val};
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_en) begin
            r_rd_data <= mem[rd_addr];
        end
    end

    // request registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_act <= t_action'(i_action);
            r_key <= i_req_key;
            r_val <= i_req_value;
            r_idx <= i_slot_index;
        end
    end

    // scan pointer and compare stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv   <= 1'b0;
            r_scan <= '0;
        end else if (i_cmd.load) begin
            r_pv   <= 1'b0;
            r_scan <= '0;
        end else begin
            r_pv <= i_cmd.scan;
            if (i_cmd.scan) begin
                r_scan <= r_scan + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.scan) begin
            r_pidx <= AW'(r_scan);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.cnt_inc) begin
            r_count <= r_count + CW'(1);
        end else if (i_cmd.cnt_dec) begin
            r_count <= r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.res_set) begin
            r_res_ok   <= i_cmd.res_ok;
            r_res_kind <= i_cmd.res_kind;
        end
    end

    // output register, holds a finished result until its transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_ok     <= r_res_ok;
            r_fkey   <= (r_res_kind == RES_PAIR) ? FOUND_W'(rd_key) : '0;
            r_fval   <= (r_res_kind != RES_NONE) ? FOUND_W'(rd_val) : '0;
            r_ecount <= COUNT_OUT_W'(r_count);
        end
    end

    assign o_valid       = r_out_valid;
    assign o_ok          = r_ok;
    assign o_found_key   = r_fkey;
    assign o_found_value = r_fval;
    assign o_entry_count = r_ecount;

    always_comb begin
        o_sts.act         = r_act;
        o_sts.match       = r_pv && (rd_key == r_key);
        o_sts.miss        = !r_pv && (r_scan >= r_count);
        o_sts.scan_more   = (r_scan < r_count);
        o_sts.full        = (r_count == CW'(CAPACITY));
        o_sts.hit_is_last = (r_pidx == last_slot);
        o_sts.idx_ok      = (XW'(r_idx) < XW'(r_count));
        o_sts.out_free    = !r_out_valid || !i_stall;
    end

    `include "assert_macros.svh"

    `ASSERT_HOLDS(a_count_step, $past(i_rst_n) |-> (r_count == $past(r_count) || r_count == $past(r_count) + CW'(1) || r_count == $past(r_count) - CW'(1)), "entry count moved by more than one")
    `ASSERT_IMPLIES(a_append_writes, i_cmd.cnt_inc, i_cmd.wr_en && i_cmd.wr_sel == WR_APPEND && r_count < CW'(CAPACITY), "count grew without an append")
    `ASSERT_IMPLIES(a_out_free, i_cmd.out_load, !r_out_valid || !i_stall, "result overwrote an untaken result")
    `ASSERT_IMPLIES(a_scan_stops, i_cmd.scan, !o_sts.match && r_scan < r_count, "scan ran past a hit or the count")

endmodule

>>> rtl/fixed_capacity_key_value_table.sv
// top level of the fixed-capacity key/value table
//
//  channel   direction  handshake            fields
//  request   in         i_valid / o_stall    i_action i_req_key i_req_value i_slot_index
//  result    out        o_valid / i_stall    o_ok o_found_key o_found_value o_entry_count
//
// one request at a time; a key search reads one slot per cycle from the slot memory,
// so a hit in slot k ends the search after slots 0 to k, a miss after all entry_count slots,
// and an erase that moves a pair also passes the move state ST_MOVE after its hit
// read by index and undefined actions take no search and go straight to the result
// reset clears state, counters, valid bits, not slots; slots are read only once written
// a finished result waits in the output register while the next request is taken;
// a further result waits until that register is free
module fixed_capacity_key_value_table #(
    parameter int CAPACITY   = fckvt_pkg::CAPACITY_DEF,
    parameter int KEY_BITS   = fckvt_pkg::KEY_BITS_DEF,
    parameter int VALUE_BITS = fckvt_pkg::VALUE_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic [fckvt_pkg::ACTION_W-1:0]      i_action,
    input  logic [KEY_BITS-1:0]                 i_req_key,
    input  logic [VALUE_BITS-1:0]               i_req_value,
    input  logic [fckvt_pkg::INDEX_W-1:0]       i_slot_index,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic                                o_ok,
    output logic [fckvt_pkg::FOUND_W-1:0]       o_found_key,
    output logic [fckvt_pkg::FOUND_W-1:0]       o_found_value,
    output logic [fckvt_pkg::COUNT_OUT_W-1:0]   o_entry_count
);
    import fckvt_pkg::*;

    t_cmd cmd;
    t_sts sts;

    fckvt_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_stall (o_stall)
    );

    fckvt_dpath #(
        .CAPACITY   (CAPACITY),
        .KEY_BITS   (KEY_BITS),
        .VALUE_BITS (VALUE_BITS)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_action      (i_action),
        .i_req_key     (i_req_key),
        .i_req_value   (i_req_value),
        .i_slot_index  (i_slot_index),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_ok          (o_ok),
        .o_found_key   (o_found_key),
        .o_found_value (o_found_value),
        .o_entry_count (o_entry_count)
    );

endmodule
